### hdl/btec_pkg.sv
`timescale 1ns / 1ps

package btec_pkg;

	localparam int unsigned BASE_SLOTS   = 4;
	localparam int unsigned BLOCK_SHIFT  = 17;
	localparam int unsigned EXT_SIZE_BIT = 11 + 17;
	localparam logic [31:0] SMALL_SIZE   = 32'h0002_0000;
	localparam int unsigned MASK_W       = 15;
	localparam int unsigned IN_DATA_W    = 112;
	localparam int unsigned IN_USER_W    = 2;
	localparam int unsigned OUT_DATA_W   = 88;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_BAD_SLOT  = 3'd1,
		STAT_BAD_SIZE  = 3'd2,
		STAT_VIRT_MIS  = 3'd3,
		STAT_PHYS_MIS  = 3'd4,
		STAT_WRAPS     = 3'd5,
		STAT_BAD_IATTR = 3'd6,
		STAT_OVERLAP   = 3'd7
	} status_t;

	typedef enum logic {
		KIND_SET  = 1'b0,
		KIND_READ = 1'b1
	} kind_t;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_CHECK  = 5'b00010,
		S_SCAN   = 5'b00100,
		S_COMMIT = 5'b01000,
		S_RESP   = 5'b10000
	} state_t;

endpackage

### hdl/block_translation_entry_checker.sv
`timescale 1ns / 1ps

// Channel  | Dir | Signals                          | Contents
// s_axis   | in  | tvalid tready tdata[111:0] tuser | one set or read request
// m_axis   | out | tvalid tready tdata[87:0]        | one status and entry result
// cfg      | in  | cfg_wr_en cfg_wr_data            | eight_slot_cpu register
//
// A read, or a request that fails before the overlap scan, goes from the check state
// straight to the response state. A set request that reaches the scan passes through
// the scan and commit states as well, scanning 1 to SLOTS_PER_SIDE entries, one
// entry per cycle through the shared range comparator, and stopping at the first hit.
// s_axis_tready is high only when the sequencer is idle; the result register
// holds while m_axis_tready is low, and a new request may be taken meanwhile.
// Reset clears all entry words, in-use bits, enables and the register.

module block_translation_entry_checker #(
	parameter int unsigned SLOTS_PER_SIDE = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic                               cfg_wr_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// slot[3:0] virt_base[35:4] phys_base[67:36] block_size[99:68] write_through[100]
	// no_cache[101] coherent[102] guarded[103] read_write[104] user_access[105]
	input  logic [btec_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// kind[0] instruction_side[1]
	input  logic [btec_pkg::IN_USER_W-1:0]     s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// status[2:0] overlap_slot[5:3] upper_word[37:6] lower_word[69:38]
	// block_mask[84:70] high_slots_on[85] extended_sizes_on[86]
	output logic [btec_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	import btec_pkg::*;

	localparam int unsigned SLOT_W = $clog2(SLOTS_PER_SIDE);

	state_t state_q;

	logic eight_slot_cpu_q;
	logic high_en_q;
	logic ext_en_q;

	logic [SLOTS_PER_SIDE-1:0] in_use_q      [2];
	logic [31:0]               entry_upper_q [2][SLOTS_PER_SIDE];
	logic [31:0]               entry_lower_q [2][SLOTS_PER_SIDE];
	logic [31:0]               range_start_q [2][SLOTS_PER_SIDE];
	logic [31:0]               range_limit_q [2][SLOTS_PER_SIDE];

	kind_t             kind_q;
	logic              side_q;
	logic [SLOT_W-1:0] slot_q;
	logic              slot_ok_q;
	logic [31:0]       virt_q;
	logic [31:0]       phys_q;
	logic [31:0]       size_q;
	logic              wt_q, nc_q, co_q, gu_q, rw_q, us_q;

	status_t           status_q;
	logic [MASK_W-1:0] mask_q;
	logic [31:0]       lim_q;
	logic              size_ge_q;
	logic [31:0]       up_q;
	logic [31:0]       lo_q;
	logic [2:0]        overlap_q;
	logic [SLOT_W-1:0] scan_idx_q;
	logic              hit_q;
	logic [SLOT_W-1:0] hit_idx_q;

	logic              accept;
	logic              in_slot_ok;
	logic              in_slot_high;
	logic [SLOT_W-1:0] slot_idx;

	logic              size_zero, size_ones, size_pow2, size_big, size_bad;
	logic [4:0]        bit_idx;
	logic [5:0]        bit_num;
	logic [MASK_W-1:0] mask_calc;
	logic [31:0]       sm1;
	logic [32:0]       end_sum;
	status_t           check_status;

	logic              scan_hit;
	logic              scan_last;
	logic              ovl;
	logic [31:0]       up_new;
	logic [31:0]       lo_new;
	logic [31:0]       limit_new;
	logic              out_free;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign slot_idx      = slot_q;

	assign in_slot_high = (s_axis_tdata[3:0] >= 4'(BASE_SLOTS))
		&& (s_axis_tdata[3:0] < 4'(SLOTS_PER_SIDE)) && eight_slot_cpu_q;
	assign in_slot_ok   = (s_axis_tdata[3:0] < 4'(BASE_SLOTS)) || in_slot_high;

	always_comb begin
		bit_idx = '0;
		for (int i = 0; i < 32; i++) begin
			if (size_q[i]) begin
				bit_idx = bit_idx | 5'(i);
			end
		end
	end

	assign size_zero = (size_q == 32'd0);
	assign size_ones = &size_q;
	assign sm1       = size_q - 32'd1;
	assign size_pow2 = ((size_q & sm1) == 32'd0);
	assign bit_num   = size_ones ? 6'd32 : {1'b0, bit_idx};
	assign size_big  = !size_zero && (bit_num > 6'(EXT_SIZE_BIT));
	assign size_bad  = (!size_zero && !size_ones && !size_pow2)
		|| (size_big && !eight_slot_cpu_q);
	assign mask_calc = (size_zero || bit_num < 6'(BLOCK_SHIFT)) ? '0
		: MASK_W'((16'd1 << 4'(bit_num - 6'(BLOCK_SHIFT))) - 16'd1);
	assign end_sum   = {1'b0, virt_q} + {1'b0, sm1};

	always_comb begin
		if (!slot_ok_q) begin
			check_status = STAT_BAD_SLOT;
		end else if (kind_q == KIND_READ) begin
			check_status = STAT_OK;
		end else if (size_bad) begin
			check_status = STAT_BAD_SIZE;
		end else if ((virt_q & sm1) != 32'd0) begin
			check_status = STAT_VIRT_MIS;
		end else if ((phys_q & sm1) != 32'd0) begin
			check_status = STAT_PHYS_MIS;
		end else if (end_sum[32]) begin
			check_status = STAT_WRAPS;
		end else if (side_q && (gu_q || wt_q)) begin
			check_status = STAT_BAD_IATTR;
		end else begin
			check_status = STAT_OK;
		end
	end

	assign scan_hit  = in_use_q[side_q][scan_idx_q]
		&& (lim_q >= range_start_q[side_q][scan_idx_q])
		&& (virt_q <= range_limit_q[side_q][scan_idx_q]);
	assign scan_last = (scan_idx_q == SLOT_W'(SLOTS_PER_SIDE - 1));
	assign ovl       = size_ge_q && hit_q && (hit_idx_q != slot_idx);

	always_comb begin
		up_new = virt_q | (32'(mask_q) << 2) | {30'd0, 1'b1, us_q};
		if (!size_ge_q) begin
			up_new[1:0] = 2'b00;
		end
	end

	assign lo_new    = phys_q | {25'd0, wt_q, nc_q, co_q, gu_q, 1'b0, rw_q, !rw_q};
	assign limit_new = size_ge_q ? (virt_q + {mask_q, 17'h1ffff}) : virt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			eight_slot_cpu_q <= 1'b0;
			high_en_q        <= 1'b0;
			ext_en_q         <= 1'b0;
			m_axis_tvalid    <= 1'b0;
			for (int s = 0; s < 2; s++) begin
				in_use_q[s] <= '0;
				for (int k = 0; k < SLOTS_PER_SIDE; k++) begin
					entry_upper_q[s][k] <= '0;
					entry_lower_q[s][k] <= '0;
				end
			end
		end else begin
			if (cfg_wr_en) begin
				eight_slot_cpu_q <= cfg_wr_data;
			end
			if (state_q == S_RESP && out_free) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_slot_high && !high_en_q) begin
							high_en_q <= 1'b1;
							for (int s = 0; s < 2; s++) begin
								for (int k = BASE_SLOTS; k < SLOTS_PER_SIDE; k++) begin
									entry_upper_q[s][k] <= '0;
									entry_lower_q[s][k] <= '0;
								end
							end
						end
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (kind_q == KIND_SET && slot_ok_q && !size_bad && size_big) begin
						ext_en_q <= 1'b1;
					end
					if (kind_q == KIND_SET && check_status == STAT_OK) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_SCAN: begin
					if (scan_hit || scan_last) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (!ovl) begin
						entry_upper_q[side_q][slot_idx] <= up_new;
						entry_lower_q[side_q][slot_idx] <= lo_new;
						in_use_q[side_q][slot_idx]      <= size_ge_q;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_q    <= kind_t'(s_axis_tuser[0]);
					side_q    <= s_axis_tuser[1];
					slot_q    <= s_axis_tdata[SLOT_W-1:0];
					virt_q    <= s_axis_tdata[35:4];
					phys_q    <= s_axis_tdata[67:36];
					size_q    <= s_axis_tdata[99:68];
					wt_q      <= s_axis_tdata[100];
					nc_q      <= s_axis_tdata[101];
					co_q      <= s_axis_tdata[102];
					gu_q      <= s_axis_tdata[103];
					rw_q      <= s_axis_tdata[104];
					us_q      <= s_axis_tdata[105];
					slot_ok_q <= in_slot_ok;
				end
			end
			S_CHECK: begin
				status_q   <= check_status;
				overlap_q  <= '0;
				lim_q      <= end_sum[31:0];
				size_ge_q  <= (size_q >= SMALL_SIZE);
				scan_idx_q <= '0;
				hit_q      <= 1'b0;
				hit_idx_q  <= '0;
				if (kind_q == KIND_SET && slot_ok_q && !size_bad) begin
					mask_q <= mask_calc;
				end else begin
					mask_q <= '0;
				end
				if (kind_q == KIND_READ && slot_ok_q) begin
					up_q <= entry_upper_q[side_q][slot_idx];
					lo_q <= entry_lower_q[side_q][slot_idx];
				end else begin
					up_q <= '0;
					lo_q <= '0;
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					hit_q     <= 1'b1;
					hit_idx_q <= scan_idx_q;
				end else if (!scan_last) begin
					scan_idx_q <= scan_idx_q + SLOT_W'(1);
				end
			end
			S_COMMIT: begin
				if (ovl) begin
					status_q  <= STAT_OVERLAP;
					overlap_q <= 3'(hit_idx_q);
				end else begin
					up_q                            <= up_new;
					lo_q                            <= lo_new;
					range_start_q[side_q][slot_idx] <= virt_q;
					range_limit_q[side_q][slot_idx] <= limit_new;
				end
			end
			S_RESP: begin
				if (out_free) begin
					m_axis_tdata <= {1'b0, ext_en_q, high_en_q, mask_q, lo_q, up_q,
						overlap_q, 3'(status_q)};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import btec_pkg::*;

	localparam int unsigned SLOTS = 8;

	typedef struct packed {
		kind_t       kind;
		logic        side;
		logic        us;
		logic        rw;
		logic        gu;
		logic        co;
		logic        nc;
		logic        wt;
		logic [31:0] size;
		logic [31:0] phys;
		logic [31:0] virt;
		logic [3:0]  slot;
	} req_t;

	typedef struct packed {
		logic          ext;
		logic          hi;
		logic [14:0]   mask;
		logic [31:0]   lower;
		logic [31:0]   upper;
		logic [2:0]    ovl;
		status_t       status;
	} res_t;

	typedef struct packed {
		bit   wr_mode;
		bit   mode;
		req_t req;
		bit   fixed;
		res_t exp;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic                  cfg_wr_data = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	logic [31:0] ent_start [0:1][0:SLOTS-1];
	logic [31:0] ent_limit [0:1][0:SLOTS-1];
	logic [31:0] ent_upper [0:1][0:SLOTS-1];
	logic [31:0] ent_lower [0:1][0:SLOTS-1];
	logic [7:0]  ent_in_use [0:1];
	logic        hi_en;
	logic        ext_en;
	logic        eight_slot_mode;

	res_t     pending_results [$];
	dir_row_t dir_rows [$];
	int       errors = 0;
	int       result_count = 0;
	int       stall_left = 0;
	logic     no_idle = 1'b0;
	logic     calm = 1'b0;
	res_t     got;
	res_t     want;

	block_translation_entry_checker #(
		.SLOTS_PER_SIDE(SLOTS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic res_t compute_entry_result(input req_t r);
		res_t        o;
		logic        slot_valid;
		logic        size_fail;
		logic [31:0] m;
		logic [31:0] sm1;
		logic [31:0] lim;
		logic [63:0] span_end;
		int          bit_n;
		int          hit;
		int          s;
		int          k;
		int          sd;
		int          sl;
		o = '0;
		o.status = STAT_OK;
		sd = int'(r.side);
		sl = int'(r.slot);
		if (sl < BASE_SLOTS) begin
			slot_valid = 1'b1;
		end else if (sl >= SLOTS || !eight_slot_mode) begin
			slot_valid = 1'b0;
		end else begin
			if (!hi_en) begin
				for (s = 0; s < 2; s++)
					for (k = BASE_SLOTS; k < SLOTS; k++) begin
						ent_upper[s][k] = '0;
						ent_lower[s][k] = '0;
					end
				hi_en = 1'b1;
			end
			slot_valid = 1'b1;
		end

		if (!slot_valid) begin
			o.status = STAT_BAD_SLOT;
		end else if (r.kind == KIND_READ) begin
			o.upper = ent_upper[sd][sl];
			o.lower = ent_lower[sd][sl];
		end else begin
			size_fail = 1'b0;
			m = '0;
			bit_n = 0;
			if (r.size != 32'd0) begin
				if (r.size == 32'hffff_ffff)
					bit_n = 32;
				else if ((r.size & (r.size - 32'd1)) != 32'd0)
					size_fail = 1'b1;
				else
					while ((r.size >> bit_n) != 32'd1) bit_n++;
				if (!size_fail && bit_n > EXT_SIZE_BIT) begin
					if (!eight_slot_mode)
						size_fail = 1'b1;
					else
						ext_en = 1'b1;
				end
				if (!size_fail && bit_n >= BLOCK_SHIFT)
					m = (32'd1 << (bit_n - BLOCK_SHIFT)) - 32'd1;
			end

			if (size_fail) begin
				o.status = STAT_BAD_SIZE;
			end else begin
				o.mask = m[14:0];
				sm1 = r.size - 32'd1;
				lim = r.virt + sm1;
				if ((r.virt & sm1) != 32'd0) begin
					o.status = STAT_VIRT_MIS;
				end else if ((r.phys & sm1) != 32'd0) begin
					o.status = STAT_PHYS_MIS;
				end else if (lim < r.virt) begin
					o.status = STAT_WRAPS;
				end else if (r.side && (r.gu || r.wt)) begin
					o.status = STAT_BAD_IATTR;
				end else begin
					hit = -1;
					for (k = 0; k < SLOTS; k++)
						if (hit < 0 && ent_in_use[sd][k] && lim >= ent_start[sd][k]
								&& r.virt <= ent_limit[sd][k])
							hit = k;
					if (r.size >= SMALL_SIZE && hit >= 0 && hit != sl) begin
						o.status = STAT_OVERLAP;
						o.ovl = hit[2:0];
					end else begin
						o.upper = r.virt | (m << 2) | 32'd2 | {31'd0, r.us};
						o.lower = r.phys | {25'd0, r.wt, r.nc, r.co, r.gu, 3'd0}
							| (r.rw ? 32'd2 : 32'd1);
						span_end = {32'd0, r.virt} + (({32'd0, m} + 64'd1) << BLOCK_SHIFT)
							- 64'd1;
						ent_start[sd][sl] = r.virt;
						ent_limit[sd][sl] = span_end[31:0];
						ent_in_use[sd][sl] = 1'b1;
						// small blocks are stored disabled
						if (r.size < SMALL_SIZE) begin
							o.upper[1:0] = 2'b00;
							ent_in_use[sd][sl] = 1'b0;
							ent_limit[sd][sl] = r.virt;
						end
						ent_upper[sd][sl] = o.upper;
						ent_lower[sd][sl] = o.lower;
					end
				end
			end
		end
		o.hi = hi_en;
		o.ext = ext_en;
		return o;
	endfunction

	function automatic req_t random_request();
		req_t        r;
		int          pick;
		logic [31:0] sz;
		r = '0;
		r.kind = ($urandom_range(0, 3) == 0) ? KIND_READ : KIND_SET;
		r.side = 1'($urandom_range(0, 1));
		r.slot = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
			: 4'($urandom_range(0, 7));
		{r.us, r.rw, r.gu, r.co, r.nc, r.wt} = 6'($urandom);
		if (r.side && $urandom_range(0, 3) != 0) begin
			r.gu = 1'b0;
			r.wt = 1'b0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 4)
			sz = '0;
		else if (pick < 9)
			sz = '1;
		else if (pick < 24)
			sz = 32'd1 << $urandom_range(0, 16);
		else if (pick < 78)
			sz = 32'd1 << $urandom_range(17, 24);
		else if (pick < 90)
			sz = 32'd1 << $urandom_range(25, 31);
		else
			sz = $urandom;
		r.size = sz;
		r.virt = $urandom;
		// crowd half the blocks into the low 64M so they collide
		if ($urandom_range(0, 1))
			r.virt[31:26] = '0;
		r.phys = $urandom;
		if ($urandom_range(0, 19) != 0) begin
			r.virt &= ~(sz - 32'd1);
			r.phys &= ~(sz - 32'd1);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 100)
			$display("[%0t] transaction %0d: %s", $realtime, result_count, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] g, input logic [31:0] w);
		if (g !== w)
			report_mismatch($sformatf("%s got %h want %h", name, g, w));
	endtask

	task automatic add_row(input bit wr, input bit mode, input kind_t kind, input logic side,
			input logic [3:0] slot, input logic [31:0] virt, input logic [31:0] phys,
			input logic [31:0] size, input logic [5:0] attrs, input bit fixed,
			input status_t st, input logic [14:0] msk, input logic [31:0] up,
			input logic [31:0] lo);
		dir_row_t row;
		row = '0;
		row.wr_mode = wr;
		row.mode = mode;
		row.req.kind = kind;
		row.req.side = side;
		row.req.slot = slot;
		row.req.virt = virt;
		row.req.phys = phys;
		row.req.size = size;
		{row.req.us, row.req.rw, row.req.gu, row.req.co, row.req.nc, row.req.wt} = attrs;
		row.fixed = fixed;
		row.exp.status = st;
		row.exp.mask = msk;
		row.exp.upper = up;
		row.exp.lower = lo;
		dir_rows.push_back(row);
	endtask

	task automatic wait_drained(input int extra);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_mode(input logic v);
		wait_drained(4);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		eight_slot_mode = v;
	endtask

	task automatic sender_gap();
		if (!no_idle && !calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic send_request(input req_t r, input bit fixed, input res_t fx);
		res_t w;
		s_axis_tdata <= {6'd0, r[105:0]};
		s_axis_tuser <= {r.side, r.kind};
		s_axis_tvalid <= 1'b1;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		w = compute_entry_result(r);
		if (fixed) begin
			w.status = fx.status;
			w.mask = fx.mask;
			w.upper = fx.upper;
			w.lower = fx.lower;
		end
		pending_results.push_back(w);
	endtask

	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0)
			calm <= !calm;
	end

	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (!no_idle && !calm && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 8);
		m_axis_tready <= (stall_left == 0);
	end

	// sample at the falling edge what the next rising edge will transfer
	always @(negedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[86:0];
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending");
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(got.status), 32'(want.status));
				check_field("overlap_slot", 32'(got.ovl), 32'(want.ovl));
				check_field("upper_word", got.upper, want.upper);
				check_field("lower_word", got.lower, want.lower);
				check_field("block_mask", 32'(got.mask), 32'(want.mask));
				check_field("high_slots_on", 32'(got.hi), 32'(want.hi));
				check_field("extended_sizes_on", 32'(got.ext), 32'(want.ext));
			end
			result_count++;
		end
	end

	initial begin
		#2_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		int s;
		int k;
		int ph;
		int n;
		for (s = 0; s < 2; s++) begin
			for (k = 0; k < SLOTS; k++) begin
				ent_start[s][k] = '0;
				ent_limit[s][k] = '0;
				ent_upper[s][k] = '0;
				ent_lower[s][k] = '0;
			end
			ent_in_use[s] = '0;
		end
		hi_en = 1'b0;
		ext_en = 1'b0;
		eight_slot_mode = 1'b0;

		// wr mode kind side slot virt phys size {us,rw,gu,co,nc,wt} fixed status mask up lo
		add_row(1, 0, KIND_READ, 0, 4'd0, 32'h0, 32'h0, 32'h0, 6'h00,
			1, STAT_OK, 15'h0, 32'h0, 32'h0);
		add_row(0, 0, KIND_READ, 1, 4'd15, 32'h0, 32'h0, 32'h0, 6'h00,
			1, STAT_BAD_SLOT, 15'h0, 32'h0, 32'h0);
		add_row(0, 0, KIND_SET, 0, 4'd4, 32'h0, 32'h0, 32'h0002_0000, 6'h00,
			1, STAT_BAD_SLOT, 15'h0, 32'h0, 32'h0);
		add_row(0, 0, KIND_SET, 0, 4'd0, 32'h0, 32'h0, 32'h3, 6'h00,
			1, STAT_BAD_SIZE, 15'h0, 32'h0, 32'h0);
		add_row(0, 0, KIND_SET, 0, 4'd0, 32'h0, 32'h0, 32'h2000_0000, 6'h00,
			1, STAT_BAD_SIZE, 15'h0, 32'h0, 32'h0);
		add_row(0, 0, KIND_SET, 0, 4'd0, 32'hffff_ffff, 32'h0, 32'h0002_0000, 6'h00,
			1, STAT_VIRT_MIS, 15'h0, 32'h0, 32'h0);
		add_row(0, 0, KIND_SET, 0, 4'd0, 32'h0, 32'hffff_0000, 32'h0002_0000, 6'h00,
			1, STAT_PHYS_MIS, 15'h0, 32'h0, 32'h0);
		add_row(0, 0, KIND_SET, 1, 4'd0, 32'h0, 32'h0, 32'h0002_0000, 6'b001001,
			1, STAT_BAD_IATTR, 15'h0, 32'h0, 32'h0);
		add_row(0, 0, KIND_SET, 0, 4'd0, 32'h0, 32'h4000_0000, 32'h1000_0000, 6'b010000,
			1, STAT_OK, 15'h07ff, 32'h0000_1ffe, 32'h4000_0002);
		add_row(0, 0, KIND_SET, 0, 4'd1, 32'h0800_0000, 32'h0, 32'h0002_0000, 6'h00,
			1, STAT_OVERLAP, 15'h0, 32'h0, 32'h0);
		add_row(0, 0, KIND_SET, 0, 4'd0, 32'h0, 32'h0, 32'h0800_0000, 6'b111111,
			0, STAT_OK, 15'h0, 32'h0, 32'h0);
		add_row(0, 0, KIND_SET, 0, 4'd2, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
			6'b100000, 0, STAT_OK, 15'h0, 32'h0, 32'h0);
		add_row(0, 0, KIND_READ, 0, 4'd2, 32'h0, 32'h0, 32'h0, 6'h00,
			0, STAT_OK, 15'h0, 32'h0, 32'h0);
		add_row(0, 0, KIND_SET, 0, 4'd3, 32'h0, 32'h0, 32'h0, 6'b010110,
			0, STAT_OK, 15'h0, 32'h0, 32'h0);
		add_row(0, 0, KIND_SET, 1, 4'd1, 32'hf000_0000, 32'hf000_0000, 32'h1000_0000,
			6'b110110, 0, STAT_OK, 15'h0, 32'h0, 32'h0);
		add_row(0, 0, KIND_READ, 1, 4'd1, 32'h0, 32'h0, 32'h0, 6'h00,
			0, STAT_OK, 15'h0, 32'h0, 32'h0);
		add_row(1, 1, KIND_SET, 0, 4'd7, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			6'h00, 0, STAT_OK, 15'h0, 32'h0, 32'h0);
		add_row(0, 0, KIND_READ, 1, 4'd5, 32'h0, 32'h0, 32'h0, 6'h00,
			1, STAT_OK, 15'h0, 32'h0, 32'h0);
		add_row(0, 0, KIND_SET, 1, 4'd4, 32'h0, 32'h0, 32'hffff_ffff, 6'h00,
			1, STAT_OVERLAP, 15'h7fff, 32'h0, 32'h0);
		add_row(0, 0, KIND_SET, 0, 4'd8, 32'h0, 32'h0, 32'h0002_0000, 6'h00,
			1, STAT_BAD_SLOT, 15'h0, 32'h0, 32'h0);
		add_row(0, 0, KIND_SET, 0, 4'd6, 32'h1, 32'h1, 32'hffff_ffff, 6'h00,
			0, STAT_OK, 15'h0, 32'h0, 32'h0);
		add_row(0, 0, KIND_READ, 0, 4'd7, 32'h0, 32'h0, 32'h0, 6'h00,
			0, STAT_OK, 15'h0, 32'h0, 32'h0);
		add_row(1, 0, KIND_READ, 0, 4'd5, 32'h0, 32'h0, 32'h0, 6'h00,
			1, STAT_BAD_SLOT, 15'h0, 32'h0, 32'h0);
		add_row(0, 0, KIND_SET, 0, 4'd1, 32'h0, 32'h0, 32'h4000_0000, 6'h00,
			1, STAT_BAD_SIZE, 15'h0, 32'h0, 32'h0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].wr_mode)
				write_mode(dir_rows[i].mode);
			sender_gap();
			send_request(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].exp);
		end

		for (ph = 0; ph < 4; ph++) begin
			write_mode(ph != 1);
			for (n = 0; n < 500; n++) begin
				if (ph == 3 && n == 250)
					no_idle <= 1'b1;
				sender_gap();
				send_request(random_request(), 1'b0, '0);
			end
		end

		wait_drained(20);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
